FILE: rtl/assert_macros.svh
// assertion macros used by the checker file cpa_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising edge, masked while reset is held
`define CPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpa assertion failed");

// property checked on every rising edge, reset included
`define CPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cpa assertion failed");

`endif

FILE: rtl/cpa_pkg.sv
// types, constants and helper functions for the covering prefix aggregator
// no dependencies
package cpa_pkg;

    localparam int ADDR_BITS   = 128;
    localparam int HALF_BITS   = 64;
    localparam int PREFIX_W    = 8;
    localparam int IN_DATA_W   = 136;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 264;

    localparam logic [PREFIX_W-1:0] FULL_PREFIX = 8'd128;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [PREFIX_W-1:0]  t_prefix;

    typedef struct packed {
        t_addr   min_addr;
        t_addr   max_addr;
        t_prefix run_prefix;
    } t_bounds;

    // values above 128 act as 128
    function automatic t_prefix clamp_prefix(input t_prefix p);
        return (p > FULL_PREFIX) ? FULL_PREFIX : p;
    endfunction

    // leading zero count of a 128-bit word, binary search in seven steps
    function automatic t_prefix lzc128(input t_addr v);
        t_addr      w;
        logic [6:0] n;
        w = v;
        n = '0;
        if (w[127:64] == 64'd0) begin
            n[6] = 1'b1;
            w    = {w[63:0], 64'd0};
        end
        if (w[127:96] == 32'd0) begin
            n[5] = 1'b1;
            w    = {w[95:0], 32'd0};
        end
        if (w[127:112] == 16'd0) begin
            n[4] = 1'b1;
            w    = {w[111:0], 16'd0};
        end
        if (w[127:120] == 8'd0) begin
            n[3] = 1'b1;
            w    = {w[119:0], 8'd0};
        end
        if (w[127:124] == 4'd0) begin
            n[2] = 1'b1;
            w    = {w[123:0], 4'd0};
        end
        if (w[127:126] == 2'd0) begin
            n[1] = 1'b1;
            w    = {w[125:0], 2'd0};
        end
        if (w[127] == 1'b0) begin
            n[0] = 1'b1;
        end
        return (v == '0) ? FULL_PREFIX : {1'b0, n};
    endfunction

endpackage

FILE: rtl/cpa_bounds.sv
// set state: lowest and highest address and smallest given prefix
// depends on cpa_pkg
module cpa_bounds (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cpa_pkg::t_addr   i_addr,
    input  cpa_pkg::t_prefix i_given_prefix,
    input  logic             i_has_prefix,
    input  logic             i_first,
    output cpa_pkg::t_bounds o_bounds
);
    import cpa_pkg::*;

    t_bounds r_bounds;
    t_bounds n_bounds;
    t_prefix gp;

    assign gp = clamp_prefix(i_given_prefix);

    always_comb begin
        n_bounds = r_bounds;
        if (i_first) begin
            n_bounds.min_addr   = i_addr;
            n_bounds.max_addr   = i_addr;
            n_bounds.run_prefix = i_has_prefix ? gp : FULL_PREFIX;
        end else begin
            // an address below the minimum never also moves the maximum
            if (i_addr < r_bounds.min_addr) begin
                n_bounds.min_addr = i_addr;
            end else if (i_addr > r_bounds.max_addr) begin
                n_bounds.max_addr = i_addr;
            end
            if (i_has_prefix && (gp < r_bounds.run_prefix)) begin
                n_bounds.run_prefix = gp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.min_addr   <= '0;
            r_bounds.max_addr   <= '0;
            r_bounds.run_prefix <= FULL_PREFIX;
        end else if (i_load) begin
            r_bounds <= n_bounds;
        end
    end

    assign o_bounds = r_bounds;

endmodule

FILE: rtl/cpa_cover.sv
// covering prefix, network and broadcast computation with result register
// depends on cpa_pkg
module cpa_cover (
    input  logic             i_clk,
    input  logic             i_load,
    input  cpa_pkg::t_bounds i_bounds,
    input  cpa_pkg::t_prefix i_prefix_limit,
    output cpa_pkg::t_prefix o_cover,
    output cpa_pkg::t_addr   o_network,
    output cpa_pkg::t_addr   o_broadcast
);
    import cpa_pkg::*;

    t_prefix common;
    t_prefix limit;
    t_prefix n_cover;
    t_addr   mask;
    t_prefix r_cover;
    t_addr   r_network;
    t_addr   r_broadcast;

    assign common = lzc128(i_bounds.min_addr ^ i_bounds.max_addr);
    assign limit  = clamp_prefix(i_prefix_limit);

    always_comb begin
        n_cover = limit;
        if (i_bounds.run_prefix < n_cover) begin
            n_cover = i_bounds.run_prefix;
        end
        if (common < n_cover) begin
            n_cover = common;
        end
    end

    // top n_cover bits set; a shift by 128 clears every bit
    assign mask = ~({ADDR_BITS{1'b1}} >> n_cover);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cover     <= n_cover;
            r_network   <= i_bounds.min_addr & mask;
            r_broadcast <= i_bounds.min_addr | ~mask;
        end
    end

    assign o_cover     = r_cover;
    assign o_network   = r_network;
    assign o_broadcast = r_broadcast;

endmodule

FILE: rtl/covering_prefix_aggregator_top.sv
// channel   dir  width  contents
// s_axis    in   136+2  address and given prefix, flags in tuser
// m_axis    out  264    cover prefix, network and broadcast addresses
// cfg       in   8      prefix limit, write only
//
// one item per cycle sustained while the output is not stalled; a result is registered after its beat:
// the state registers take the beat, the result register holds the answer
// a stalled result still lets one further beat into the state registers
// synchronous active-low reset: set state zero, running prefix and limit 128
// depends on cpa_pkg, cpa_bounds, cpa_cover
module covering_prefix_aggregator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // addr_upper[63:0], addr_lower[127:64], given_prefix[135:128]
    input  logic [cpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // has_prefix[0], first_of_set[1]
    input  logic [cpa_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cover_prefix[7:0], network_upper[71:8], network_lower[135:72],
    // broadcast_upper[199:136], broadcast_lower[263:200]
    output logic [cpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [cpa_pkg::PREFIX_W-1:0]     i_cfg_wdata
);
    import cpa_pkg::*;

    logic    r_s1_vld;
    logic    n_s1_vld;
    logic    r_out_vld;
    logic    n_out_vld;
    logic    s1_go;
    logic    accept;
    t_prefix r_prefix_limit;
    t_bounds bounds;
    t_addr   in_addr;
    t_prefix cover_len;
    t_addr   network;
    t_addr   broadcast;

    assign s1_go         = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign n_s1_vld  = accept ? 1'b1 : (s1_go ? 1'b0 : r_s1_vld);
    assign n_out_vld = s1_go ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_prefix_limit <= FULL_PREFIX;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_prefix_limit <= i_cfg_wdata;
            end
        end
    end

    assign in_addr = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    cpa_bounds u_bounds (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_addr         (in_addr),
        .i_given_prefix (s_axis_tdata[135:128]),
        .i_has_prefix   (s_axis_tuser[0]),
        .i_first        (s_axis_tuser[1]),
        .o_bounds       (bounds)
    );

    cpa_cover u_cover (
        .i_clk          (i_clk),
        .i_load         (s1_go),
        .i_bounds       (bounds),
        .i_prefix_limit (r_prefix_limit),
        .o_cover        (cover_len),
        .o_network      (network),
        .o_broadcast    (broadcast)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {broadcast[63:0], broadcast[127:64],
                            network[63:0], network[127:64], cover_len};

endmodule

FILE: rtl/cpa_checker.sv
// port-level checks for the covering prefix aggregator, bound to the top level
// depends on assert_macros.svh and cpa_pkg
`include "assert_macros.svh"

module cpa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import cpa_pkg::*;

    t_prefix o_cover;
    t_addr   o_net;
    t_addr   o_bc;
    t_addr   host_bits;
    logic    out_stall;

    assign o_cover   = m_axis_tdata[7:0];
    assign o_net     = {m_axis_tdata[71:8], m_axis_tdata[135:72]};
    assign o_bc      = {m_axis_tdata[199:136], m_axis_tdata[263:200]};
    assign host_bits = {ADDR_BITS{1'b1}} >> o_cover;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // nothing leaves the block in the cycle after reset
    `CPA_ASSERT_ALWAYS(a_no_out_after_rst, i_clk, !i_rst_n |=> !m_axis_tvalid)

    `CPA_ASSERT(a_cover_range, i_clk, i_rst_n, m_axis_tvalid |-> (o_cover <= FULL_PREFIX))

    // every bit set in the network address is also set in the broadcast address
    `CPA_ASSERT(a_net_in_bc, i_clk, i_rst_n, m_axis_tvalid |-> ((o_net & ~o_bc) == '0))

    `CPA_ASSERT(a_cover_host_bits, i_clk, i_rst_n, m_axis_tvalid |-> ((o_net ^ o_bc) == host_bits))

    `CPA_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind covering_prefix_aggregator_top cpa_checker u_cpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
